// File: sv/uart_can_frame_parser_assert.svh
// Assertion macros shared by the frame parser modules.
// Each macro expects a clock and an active-high synchronous reset as arguments.
`ifndef UART_CAN_FRAME_PARSER_ASSERT_SVH
`define UART_CAN_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UCFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// Next-cycle implication, checked outside reset.
`define UCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

// File: sv/ucfp_pkg.sv
// Package for the delimited serial frame parser: parser states, the command
// and status structs between controller and datapath, and register constants.
// No dependencies.
package ucfp_pkg;

  // Configuration register map.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE   = 2'd1;

  // Register reset values.
  localparam logic [7:0] START_BYTE_RESET = 8'hAA;
  localparam logic [7:0] END_BYTE_RESET   = 8'h55;

  // Parser states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ID_HIGH,
    S_ID_LOW,
    S_LENGTH,
    S_PAYLOAD,
    S_CLOSE,
    S_EMIT_READ,
    S_EMIT_LOAD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic id_high;     // capture identifier high byte
    logic id_low;      // capture identifier low byte
    logic len_load;    // capture length and clear the payload count
    logic wr_payload;  // store one payload byte
    logic emit_start;  // clear the emit index
    logic emit_step;   // advance the emit index
    logic load_out;    // load the output register with one result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_match;   // received byte equals the start byte
    logic end_match;     // received byte equals the end byte
    logic len_ok;        // received byte is a legal length
    logic payload_done;  // current payload byte is the last of the frame
    logic emit_last;     // emit index points at the last payload byte
    logic out_free;      // output register can take a result this cycle
  } status_t;

endpackage

// File: sv/ucfp_dpath.sv
// Datapath of the frame parser: configuration registers, identifier and length
// holding registers, payload memory, emit counter and output register.
// Depends on ucfp_pkg and uart_can_frame_parser_assert.svh.
`include "uart_can_frame_parser_assert.svh"

module ucfp_dpath #(
  parameter int MAX_PAYLOAD = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [ucfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic [7:0]                       rx_byte,
  input  ucfp_pkg::cmd_t                   cmd,
  output ucfp_pkg::status_t                status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [15:0]                      frame_id,
  output logic [3:0]                       frame_length,
  output logic [3:0]                       byte_index,
  output logic [7:0]                       payload_byte,
  output logic                             last
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]    start_byte;
  logic [7:0]    end_byte;
  logic [15:0]   held_id;
  logic [CW-1:0] held_length;
  logic [CW-1:0] payload_count;
  logic [IW-1:0] emit_idx;
  logic [7:0]    payload_store [MAX_PAYLOAD];
  logic [7:0]    store_q;

  // Configuration registers; indexes beyond the map are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= ucfp_pkg::START_BYTE_RESET;
      end_byte   <= ucfp_pkg::END_BYTE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ucfp_pkg::CFG_START_BYTE) begin
        start_byte <= cfg_data;
      end else if (cfg_index == ucfp_pkg::CFG_END_BYTE) begin
        end_byte <= cfg_data;
      end
    end
  end

  // Identifier, length, and payload write counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_id       <= '0;
      held_length   <= '0;
      payload_count <= '0;
    end else begin
      if (cmd.id_high) begin
        held_id[15:8] <= rx_byte;
      end
      if (cmd.id_low) begin
        held_id[7:0] <= rx_byte;
      end
      if (cmd.len_load) begin
        held_length   <= rx_byte[CW-1:0];
        payload_count <= '0;
      end else if (cmd.wr_payload) begin
        payload_count <= payload_count + CW'(1);
      end
    end
  end

  // Payload memory with a registered read port addressed by the emit index.
  always_ff @(posedge clk) begin
    if (cmd.wr_payload) begin
      payload_store[payload_count[IW-1:0]] <= rx_byte;
    end
    store_q <= payload_store[emit_idx];
  end

  // Emit index walks the stored payload once per good frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (cmd.emit_start) begin
      emit_idx <= '0;
    end else if (cmd.emit_step) begin
      emit_idx <= emit_idx + IW'(1);
    end
  end

  // Output register; it holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frame_id     <= held_id;
      frame_length <= 4'(held_length);
      byte_index   <= 4'(emit_idx);
      payload_byte <= store_q;
      last         <= status.emit_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.start_match  = (rx_byte == start_byte);
    status.end_match    = (rx_byte == end_byte);
    status.len_ok       = (rx_byte != 8'd0) && (rx_byte <= 8'(MAX_PAYLOAD));
    status.payload_done = ((payload_count + CW'(1)) >= held_length);
    status.emit_last    = ((CW'(emit_idx) + CW'(1)) == held_length);
    status.out_free     = !out_valid || out_ready;
  end

  // Checks on the datapath.
  `UCFP_ASSERT_NOW(a_wr_in_range, clk, rst, cmd.wr_payload,
                   payload_count < CW'(MAX_PAYLOAD))
  `UCFP_ASSERT_NEXT(a_load_sets_valid, clk, rst, cmd.load_out, out_valid)
  `UCFP_ASSERT_NEXT(a_last_marked, clk, rst, cmd.load_out && status.emit_last, last)

endmodule

// File: sv/ucfp_ctrl.sv
// Controller of the frame parser: walks the frame phases on accepted bytes and
// sequences the result burst after a good end byte.
// Depends on ucfp_pkg and uart_can_frame_parser_assert.svh.
`include "uart_can_frame_parser_assert.svh"

module ucfp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ucfp_pkg::status_t status,
  output ucfp_pkg::cmd_t    cmd
);

  ucfp_pkg::state_t state;
  ucfp_pkg::state_t state_next;
  logic             accept;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ucfp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state != ucfp_pkg::S_EMIT_READ) && (state != ucfp_pkg::S_EMIT_LOAD);
    accept     = in_valid && in_ready;
    case (state)
      ucfp_pkg::S_IDLE: begin
        if (accept && status.start_match) begin
          state_next = ucfp_pkg::S_ID_HIGH;
        end
      end
      ucfp_pkg::S_ID_HIGH: begin
        if (accept) begin
          cmd.id_high = 1'b1;
          state_next  = ucfp_pkg::S_ID_LOW;
        end
      end
      ucfp_pkg::S_ID_LOW: begin
        if (accept) begin
          cmd.id_low = 1'b1;
          state_next = ucfp_pkg::S_LENGTH;
        end
      end
      ucfp_pkg::S_LENGTH: begin
        if (accept) begin
          if (status.len_ok) begin
            cmd.len_load = 1'b1;
            state_next   = ucfp_pkg::S_PAYLOAD;
          end else begin
            state_next = ucfp_pkg::S_IDLE;
          end
        end
      end
      ucfp_pkg::S_PAYLOAD: begin
        if (accept) begin
          cmd.wr_payload = 1'b1;
          if (status.payload_done) begin
            state_next = ucfp_pkg::S_CLOSE;
          end
        end
      end
      ucfp_pkg::S_CLOSE: begin
        if (accept) begin
          if (status.end_match) begin
            cmd.emit_start = 1'b1;
            state_next     = ucfp_pkg::S_EMIT_READ;
          end else begin
            state_next = ucfp_pkg::S_IDLE;
          end
        end
      end
      ucfp_pkg::S_EMIT_READ: begin
        // The payload memory read completes during this cycle.
        state_next = ucfp_pkg::S_EMIT_LOAD;
      end
      ucfp_pkg::S_EMIT_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.emit_last) begin
            state_next = ucfp_pkg::S_IDLE;
          end else begin
            cmd.emit_step = 1'b1;
            state_next    = ucfp_pkg::S_EMIT_READ;
          end
        end
      end
      default: begin
        state_next = ucfp_pkg::S_IDLE;
      end
    endcase
  end

  // Checks on the controller.
  `UCFP_ASSERT_NOW(a_no_load_while_taking, clk, rst, cmd.load_out, !in_ready)
  `UCFP_ASSERT_NOW(a_load_needs_room, clk, rst, cmd.load_out, status.out_free)
  `UCFP_ASSERT_NEXT(a_good_close_blocks_input, clk, rst, cmd.emit_start, !in_ready)

endmodule

// File: sv/uart_can_frame_parser.sv
// Delimited serial frame parser.
//
// Usage: bytes enter on the in channel (in_valid/in_ready, rx_byte). A frame is
// start byte, identifier high and low bytes, a length of 1 to MAX_PAYLOAD, that
// many payload bytes, then the end byte. Start and end byte values are set on
// the cfg channel (index 0 start, index 1 end); cfg_ready is always high.
// Bytes are taken one per cycle while a frame is being received. After a good
// end byte the block emits one result per payload byte on the out channel
// (out_valid/out_ready); each result passes through the registered read of
// the payload memory and then the output register load, and the next byte is
// read only once the previous result is loaded. in_ready is low during that
// burst. Bad lengths and bad end bytes drop the frame with no result.
// Reset returns the parser to idle, clears the output register and restores the
// start and end byte values (0xAA and 0x55). When the receiver stalls, the
// current result holds in the output register and the burst waits; outside a
// burst the block keeps taking bytes while a result is pending.
// Depends on ucfp_pkg, ucfp_ctrl and ucfp_dpath.

module uart_can_frame_parser #(
  parameter int MAX_PAYLOAD = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ucfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      frame_id,
  output logic [3:0]                       frame_length,
  output logic [3:0]                       byte_index,
  output logic [7:0]                       payload_byte,
  output logic                             last
);

  ucfp_pkg::cmd_t    cmd;
  ucfp_pkg::status_t status;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  ucfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ucfp_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .last         (last)
  );

endmodule

// File: dv/testbench.sv
// Testbench for uart_can_frame_parser: byte streams of good, broken and noisy frames
// are checked against an in-bench frame tracker, result by result, under random stalls.
// Depends on ucfp_pkg and the uart_can_frame_parser RTL.

// One emitted payload result, as seen on the out channel.
typedef struct packed {
  logic [15:0] frame_id;
  logic [3:0]  frame_length;
  logic [3:0]  byte_index;
  logic [7:0]  payload_byte;
  logic        last;
} frame_result_t;

// Follows the parser byte by byte and holds the payload results still owed by the block.
class frame_checker;
  localparam int MAX_PAYLOAD = 11;

  logic [7:0]       start_val;
  logic [7:0]       end_val;
  ucfp_pkg::state_t phase;
  logic [15:0]      held_id;
  logic [3:0]       held_length;
  logic [3:0]       payload_count;
  logic [7:0]       payload_store [MAX_PAYLOAD];
  frame_result_t    owed_results [$];
  int               errors;
  int               results_checked;

  function new();
    start_val = ucfp_pkg::START_BYTE_RESET;
    end_val = ucfp_pkg::END_BYTE_RESET;
    phase = ucfp_pkg::S_IDLE;
    held_id = '0;
    held_length = '0;
    payload_count = '0;
    errors = 0;
    results_checked = 0;
  endfunction

  // Indexes past the register map are dropped, as in the block.
  function void write_reg(logic [ucfp_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] data);
    if (idx == ucfp_pkg::CFG_START_BYTE) begin
      start_val = data;
    end else if (idx == ucfp_pkg::CFG_END_BYTE) begin
      end_val = data;
    end
  endfunction

  // Advances the parser by one accepted byte; returns 0 when the byte is ignored in idle.
  function bit take_byte(logic [7:0] b);
    frame_result_t r;
    bit engaged;
    engaged = 1'b1;
    case (phase)
      ucfp_pkg::S_IDLE: begin
        if (b == start_val) phase = ucfp_pkg::S_ID_HIGH;
        else engaged = 1'b0;
      end
      ucfp_pkg::S_ID_HIGH: begin
        held_id[15:8] = b;
        phase = ucfp_pkg::S_ID_LOW;
      end
      ucfp_pkg::S_ID_LOW: begin
        held_id[7:0] = b;
        phase = ucfp_pkg::S_LENGTH;
      end
      ucfp_pkg::S_LENGTH: begin
        if (b >= 1 && b <= MAX_PAYLOAD) begin
          held_length = b[3:0];
          payload_count = '0;
          phase = ucfp_pkg::S_PAYLOAD;
        end else begin
          phase = ucfp_pkg::S_IDLE;
        end
      end
      ucfp_pkg::S_PAYLOAD: begin
        payload_store[payload_count] = b;
        payload_count = payload_count + 4'd1;
        if (payload_count >= held_length) phase = ucfp_pkg::S_CLOSE;
      end
      ucfp_pkg::S_CLOSE: begin
        // A bad end byte drops the frame and is not reused as a start byte.
        if (b == end_val) begin
          for (int k = 0; k < held_length; k++) begin
            r.frame_id = held_id;
            r.frame_length = held_length;
            r.byte_index = k[3:0];
            r.payload_byte = payload_store[k];
            r.last = (k + 1 == held_length);
            owed_results.push_back(r);
          end
        end
        phase = ucfp_pkg::S_IDLE;
      end
      default: begin
        phase = ucfp_pkg::S_IDLE;
      end
    endcase
    return engaged;
  endfunction

  // Compares one accepted result with the oldest one owed.
  function void check_result(frame_result_t got);
    frame_result_t want;
    results_checked++;
    if (owed_results.size() == 0) begin
      if (errors < 10) begin
        $display("[%0t] unexpected result: id=%h len=%0d idx=%0d data=%h last=%b", $realtime,
                 got.frame_id, got.frame_length, got.byte_index, got.payload_byte, got.last);
      end
      errors++;
      return;
    end
    want = owed_results.pop_front();
    if (got.frame_id !== want.frame_id || got.frame_length !== want.frame_length ||
        got.byte_index !== want.byte_index || got.payload_byte !== want.payload_byte ||
        got.last !== want.last) begin
      if (errors < 10) begin
        $display("[%0t] mismatch: expected id=%h len=%0d idx=%0d data=%h last=%b", $realtime,
                 want.frame_id, want.frame_length, want.byte_index, want.payload_byte,
                 want.last);
        $display("[%0t]           actual   id=%h len=%0d idx=%0d data=%h last=%b", $realtime,
                 got.frame_id, got.frame_length, got.byte_index, got.payload_byte, got.last);
      end
      errors++;
    end
  endfunction

  function int pending();
    return owed_results.size();
  endfunction
endclass

module testbench;
  localparam int MAX_PAYLOAD = 11;
  localparam int BAD_LENGTH_MIN = 12;
  localparam logic [ucfp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [ucfp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_B = 2'd3;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 46;

  logic                             clk;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [ucfp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]                       cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  logic [7:0]                       rx_byte;
  logic                             out_valid;
  logic                             out_ready;
  logic [15:0]                      frame_id;
  logic [3:0]                       frame_length;
  logic [3:0]                       byte_index;
  logic [7:0]                       payload_byte;
  logic                             last;

  frame_checker tracker = new();
  bit idle_en;
  bit hold_request;
  bit hold_active;
  int bytes_engaged;
  int cfg_writes;
  int cycle_count;

  uart_can_frame_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_id(frame_id),
    .frame_length(frame_length),
    .byte_index(byte_index),
    .payload_byte(payload_byte),
    .last(last)
  );

  // Clock with a period of 20 time units.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               tracker.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Long receiver hold-off, so that a burst stalls and the block stops taking bytes.
  initial begin
    hold_active = 1'b0;
    wait (hold_request);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // Receiver: check each result transaction and stall at random.
  always @(posedge clk) begin : receive_side
    frame_result_t seen;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen.frame_id = frame_id;
        seen.frame_length = frame_length;
        seen.byte_index = byte_index;
        seen.payload_byte = payload_byte;
        seen.last = last;
        tracker.check_result(seen);
      end
      out_ready <= !(hold_active || (idle_en && $urandom_range(99) < 36));
    end
  end

  // Offers one byte, with random gaps ahead of it, and waits for the transaction.
  task automatic send_byte(input logic [7:0] b);
    while (idle_en && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tracker.take_byte(b)) bytes_engaged++;
  endtask

  // Register write; the caller lowers cfg_valid after the last write of a batch.
  task automatic write_register(input logic [ucfp_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic configure(input logic [7:0] start_val, input logic [7:0] end_val,
                           input bit touch_unused);
    if (touch_unused) begin
      write_register(CFG_UNUSED_A, 8'($urandom_range(255)));
      write_register(CFG_UNUSED_B, 8'($urandom_range(255)));
    end
    write_register(ucfp_pkg::CFG_START_BYTE, start_val);
    write_register(ucfp_pkg::CFG_END_BYTE, end_val);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering and waits until every owed result is out and the block has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise.
  task automatic play_traffic(input int target);
    logic [7:0] frame [$];
    int base;
    int r;
    int pick;
    int len;
    base = bytes_engaged;
    while (bytes_engaged - base < target) begin
      frame = {};
      r = $urandom_range(99);
      if (r >= 90) begin
        repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(255)));
      end else begin
        frame.push_back(tracker.start_val);
        frame.push_back(8'($urandom_range(255)));
        frame.push_back(8'($urandom_range(255)));
        if (r >= 80) begin
          frame.push_back(8'($urandom_range(1) ? 0 : $urandom_range(BAD_LENGTH_MIN, 255)));
        end else begin
          pick = $urandom_range(9);
          len = (pick < 2) ? MAX_PAYLOAD :
                (pick < 5) ? $urandom_range(1, MAX_PAYLOAD) : $urandom_range(1, 4);
          frame.push_back(8'(len));
          repeat (len) frame.push_back(8'($urandom_range(255)));
          if (r >= 70) frame.push_back(tracker.end_val ^ 8'($urandom_range(1, 255)));
          else frame.push_back(tracker.end_val);
        end
      end
      foreach (frame[i]) send_byte(frame[i]);
    end
  endtask

  // Main sequence: reset, directed frames, then random phases under several settings.
  initial begin
    logic [7:0] directed [$];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    idle_en = 1'b1;
    hold_request = 1'b0;
    bytes_engaged = 0;
    cfg_writes = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Idle noise, a one-byte frame at the field extremes, the bad lengths 0, 12 and 255,
    // and a bad end byte equal to the start byte, which must not open a new frame.
    directed = '{8'h00, 8'hFF,
                 ucfp_pkg::START_BYTE_RESET, 8'hFF, 8'hFF, 8'h01, 8'h00,
                 ucfp_pkg::END_BYTE_RESET,
                 ucfp_pkg::START_BYTE_RESET, 8'h00, 8'h00, 8'h00,
                 ucfp_pkg::START_BYTE_RESET, 8'h12, 8'h34, 8'h0C,
                 ucfp_pkg::START_BYTE_RESET, 8'h00, 8'h00, 8'hFF,
                 ucfp_pkg::START_BYTE_RESET, 8'h01, 8'h02, 8'h02, 8'hFF, 8'h80,
                 ucfp_pkg::START_BYTE_RESET,
                 ucfp_pkg::END_BYTE_RESET};
    foreach (directed[i]) send_byte(directed[i]);
    play_traffic(PHASE_ITEMS - 10);
    wait_drained();

    // Extreme register values, with writes to unused indexes; no idling on either side.
    configure(8'h00, 8'hFF, 1'b1);
    idle_en = 1'b0;
    play_traffic(PHASE_ITEMS);
    wait_drained();

    // Swapped extremes while the receiver holds off and the sender keeps offering.
    configure(8'hFF, 8'h00, 1'b0);
    idle_en = 1'b1;
    hold_request = 1'b1;
    play_traffic(PHASE_ITEMS);
    wait_drained();

    // End byte changed while a frame is open; the close must use the new value.
    send_byte(tracker.start_val);
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
    send_byte(8'd3);
    repeat (3) send_byte(8'($urandom_range(255)));
    wait_drained();
    write_register(ucfp_pkg::CFG_END_BYTE, 8'($urandom_range(255)));
    cfg_valid <= 1'b0;
    send_byte(tracker.end_val);
    wait_drained();

    // Random register values.
    configure(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
    play_traffic(PHASE_ITEMS);
    wait_drained();

    $display("Covered %0d frame bytes and %0d register writes over five settings,",
             bytes_engaged, cfg_writes);
    $display("with %0d payload results checked and %0d mismatches.",
             tracker.results_checked, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
